/* hdl/lfd_pkg.sv */
// Shared types, constants and helpers for the length field deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package lfd_pkg;

   localparam int MAX_LENGTH_BYTES = 4;
   localparam int BYTE_W           = 8;
   localparam int ACC_W            = 32;
   localparam int OFFSET_W         = 4;
   localparam int FIELD_BYTES_W    = 3;
   localparam int HDR_POS_W        = 5;
   localparam int CSR_IDX_W        = 1;
   localparam int CSR_DATA_W       = 4;
   localparam int USER_W           = 2;

   localparam logic [OFFSET_W-1:0]      OFFSET_RESET      = OFFSET_W'(3);
   localparam logic [FIELD_BYTES_W-1:0] FIELD_BYTES_RESET = FIELD_BYTES_W'(2);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LENGTH_FIELD_OFFSET = 1'b0,
      CSR_LENGTH_FIELD_BYTES  = 1'b1
   } lfd_csr_idx_type;

   // Tags produced for one stream word
   typedef struct packed {
      logic packet_start;
      logic packet_end;
      logic in_header;
   } lfd_tag_type;

   // Clamp the configured field width into 1..MAX_LENGTH_BYTES
   function automatic logic [FIELD_BYTES_W-1:0] field_width(
      input logic [FIELD_BYTES_W-1:0] nb
   );
      logic [FIELD_BYTES_W-1:0] w;
      w = nb;
      if (nb == '0) begin
         w = FIELD_BYTES_W'(1);
      end else if (nb > FIELD_BYTES_W'(MAX_LENGTH_BYTES)) begin
         w = FIELD_BYTES_W'(MAX_LENGTH_BYTES);
      end
      return w;
   endfunction

endpackage

`default_nettype wire

/* hdl/lfd_tracker.sv */
// Frame position tracker: header position, length accumulator and payload
// countdown. Tags each accepted word. Depends on lfd_pkg.
`default_nettype none

module lfd_tracker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               step,
   input  wire logic [lfd_pkg::BYTE_W-1:0]         stream_byte,
   input  wire logic [lfd_pkg::OFFSET_W-1:0]       length_field_offset,
   input  wire logic [lfd_pkg::FIELD_BYTES_W-1:0]  length_field_bytes,
   output lfd_pkg::lfd_tag_type                    tag
);
   import lfd_pkg::*;

   logic [HDR_POS_W-1:0] hdr_pos_ff, hdr_pos_in;
   logic [ACC_W-1:0]     accum_ff, accum_in;
   logic [ACC_W-1:0]     remaining_ff, remaining_in;
   logic                 payload_ff, payload_in;

   logic [HDR_POS_W-1:0] last_pos;
   logic [HDR_POS_W-1:0] offset_ext;
   logic [ACC_W-1:0]     accum_base;
   logic [ACC_W-1:0]     accum_new;
   logic [ACC_W-1:0]     remaining_dec;
   logic                 in_field;

   assign offset_ext = HDR_POS_W'(length_field_offset);
   assign last_pos   = offset_ext + HDR_POS_W'(field_width(length_field_bytes))
                       - HDR_POS_W'(1);
   assign in_field   = (hdr_pos_ff >= offset_ext) && (hdr_pos_ff <= last_pos);
   // first header byte restarts the accumulator
   assign accum_base = (hdr_pos_ff == '0) ? '0 : accum_ff;
   assign accum_new  = in_field ? {accum_base[ACC_W-BYTE_W-1:0], stream_byte}
                                : accum_base;
   assign remaining_dec = (remaining_ff != '0) ? remaining_ff - ACC_W'(1) : '0;

   always_comb begin
      hdr_pos_in   = hdr_pos_ff;
      accum_in     = accum_ff;
      remaining_in = remaining_ff;
      payload_in   = payload_ff;
      tag          = '0;
      if (!payload_ff) begin
         tag.in_header    = 1'b1;
         tag.packet_start = (hdr_pos_ff == '0);
         accum_in         = accum_new;
         if (hdr_pos_ff >= last_pos) begin
            hdr_pos_in = '0;
            if (accum_new == '0) begin
               tag.packet_end = 1'b1;
            end else begin
               remaining_in = accum_new;
               payload_in   = 1'b1;
            end
         end else begin
            hdr_pos_in = hdr_pos_ff + HDR_POS_W'(1);
         end
      end else begin
         remaining_in = remaining_dec;
         if (remaining_dec == '0) begin
            tag.packet_end = 1'b1;
            payload_in     = 1'b0;
            hdr_pos_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_pos_ff   <= '0;
         accum_ff     <= '0;
         remaining_ff <= '0;
         payload_ff   <= 1'b0;
      end else if (step) begin
         hdr_pos_ff   <= hdr_pos_in;
         accum_ff     <= accum_in;
         remaining_ff <= remaining_in;
         payload_ff   <= payload_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/length_field_deframer_core.sv */
// Length field deframer top level: configuration registers, frame tracker and
// a two-entry output buffer. Depends on lfd_pkg and lfd_tracker.
//
// Returns each accepted byte from an output register, tagged as first byte
// of a packet (tuser[0]), header byte (tuser[1]) and last byte (tlast). A
// packet is length_field_offset + length_field_bytes header bytes followed
// by the big-endian payload length they carry; a zero length ends the packet
// on its last header byte. Sustained rate is one byte per cycle while
// rsp_tready is high, as the position counter and length accumulator update
// on every accepted byte. An output register plus a skid register take one
// more byte once rsp_tready is low; req_tready drops only when both are full.
// Write configuration only while no byte is in flight.
`default_nettype none

module length_field_deframer_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request stream
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   input  wire logic [7:0]                       req_tdata,  // [7:0] stream_byte
   // response stream
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   output      logic [7:0]                       rsp_tdata,  // [7:0] out_byte
   output      logic [lfd_pkg::USER_W-1:0]       rsp_tuser,  // [0] packet_start, [1] in_header
   output      logic                             rsp_tlast,  // packet_end
   // configuration
   input  wire logic                             csr_we,
   input  wire logic [lfd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lfd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lfd_pkg::*;

   logic [OFFSET_W-1:0]      offset_ff;
   logic [FIELD_BYTES_W-1:0] nbytes_ff;

   logic        accept;
   logic        pop;
   lfd_tag_type tag;

   logic              out_valid_ff;
   logic [BYTE_W-1:0] out_byte_ff;
   lfd_tag_type       out_tag_ff;
   logic              skid_valid_ff;
   logic [BYTE_W-1:0] skid_byte_ff;
   lfd_tag_type       skid_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
         nbytes_ff <= FIELD_BYTES_RESET;
      end else if (csr_we) begin
         unique case (lfd_csr_idx_type'(csr_index))
            CSR_LENGTH_FIELD_OFFSET: offset_ff <= csr_wdata[OFFSET_W-1:0];
            CSR_LENGTH_FIELD_BYTES:  nbytes_ff <= csr_wdata[FIELD_BYTES_W-1:0];
         endcase
      end
   end

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;

   lfd_tracker u_tracker (
      .clock               (clock),
      .reset               (reset),
      .step                (accept),
      .stream_byte         (req_tdata),
      .length_field_offset (offset_ff),
      .length_field_bytes  (nbytes_ff),
      .tag                 (tag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // no accept while skid is full; drain it on pop
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_byte_ff <= skid_byte_ff;
            out_tag_ff  <= skid_tag_ff;
         end
      end else if (accept) begin
         if (out_valid_ff && !pop) begin
            skid_byte_ff <= req_tdata;
            skid_tag_ff  <= tag;
         end else begin
            out_byte_ff <= req_tdata;
            out_tag_ff  <= tag;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = {out_tag_ff.in_header, out_tag_ff.packet_start};
   assign rsp_tlast  = out_tag_ff.packet_end;

endmodule

`default_nettype wire

/* hdl/lfd_checker.sv */
// Port-level checks for length_field_deframer_core, bound to the top level.
// Depends on lfd_pkg.
`default_nettype none

module lfd_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   input  wire logic [7:0]                  rsp_tdata,
   input  wire logic [lfd_pkg::USER_W-1:0]  rsp_tuser,
   input  wire logic                        rsp_tlast
);
   import lfd_pkg::*;

   // next response word must open a packet
   logic expect_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_start_ff <= 1'b1;
      end else if (rsp_tvalid && rsp_tready) begin
         expect_start_ff <= rsp_tlast;
      end
   end

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response word changed");

   a_start_in_header: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[1])
      else $error("packet start outside header");

   a_start_after_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[0] == expect_start_ff)
      else $error("packet start does not follow packet end");

   a_reset_drains: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind length_field_deframer_core lfd_checker u_lfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

/* verif/tb_length_field_deframer_core.sv */
// Self-checking testbench for length_field_deframer_core: sends framed byte streams
// under many framing settings and checks every tagged word against a local frame tracker.
// Depends on lfd_pkg and the length_field_deframer_core RTL.
`timescale 1ns / 1ps

module tb_length_field_deframer_core;
   import lfd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 200;
   localparam int DRAIN_SLACK = 8;

   typedef struct packed {
      logic [7:0]  data;
      lfd_tag_type tag;
   } deframed_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;  // [7:0] stream_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;       // [7:0] out_byte
   logic [USER_W-1:0]     rsp_tuser;       // [0] packet_start, [1] in_header
   logic                  rsp_tlast;       // packet_end
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_LENGTH_FIELD_OFFSET;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   length_field_deframer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Framing registers and tracker state as the block should hold them
   logic [OFFSET_W-1:0]      cfg_offset;
   logic [FIELD_BYTES_W-1:0] cfg_field_bytes;
   logic [HDR_POS_W-1:0]     hdr_pos;
   logic [ACC_W-1:0]         length_accum;
   logic [ACC_W-1:0]         payload_left;
   logic                     in_payload;

   deframed_word_type pending_words[$];
   int  mismatch_count = 0;
   int  bytes_sent     = 0;
   int  words_checked  = 0;
   int  packets_closed = 0;
   int  framing_writes = 0;
   int  cycle_count    = 0;
   bit  sender_steady  = 1'b0;
   bit  sink_steady    = 1'b0;
   bit  long_hold_req  = 1'b0;
   int  hold_left      = 0;

   function automatic int active_field_bytes();
      int nb;
      nb = int'(cfg_field_bytes);
      if (nb < 1) nb = 1;
      if (nb > MAX_LENGTH_BYTES) nb = MAX_LENGTH_BYTES;
      return nb;
   endfunction

   // Advance the frame tracker by one stream byte and return its expected tags
   function automatic deframed_word_type deframe_byte(input logic [7:0] b);
      deframed_word_type w;
      int last_hdr;
      int p;
      w.data = b;
      w.tag  = '0;
      if (!in_payload) begin
         last_hdr = int'(cfg_offset) + active_field_bytes() - 1;
         p = int'(hdr_pos);
         w.tag.in_header = 1'b1;
         if (p == 0) begin
            w.tag.packet_start = 1'b1;
            length_accum = '0;
         end
         if (p >= int'(cfg_offset) && p <= last_hdr) begin
            length_accum = {length_accum[ACC_W-9:0], b};
         end
         // a position at or past the field end closes the header
         if (p >= last_hdr) begin
            hdr_pos = '0;
            if (length_accum == '0) begin
               w.tag.packet_end = 1'b1;
            end else begin
               payload_left = length_accum;
               in_payload = 1'b1;
            end
         end else begin
            hdr_pos = hdr_pos + 1'b1;
         end
      end else begin
         if (payload_left != '0) payload_left = payload_left - 1'b1;
         if (payload_left == '0) begin
            w.tag.packet_end = 1'b1;
            in_payload = 1'b0;
            hdr_pos = '0;
         end
      end
      return w;
   endfunction

   // Sender: called at a falling edge, returns at the falling edge after acceptance
   task automatic push_stream_byte(input logic [7:0] b);
      while (!sender_steady && $urandom_range(0, 99) < 10) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      pending_words.push_back(deframe_byte(b));
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(negedge clock);
   endtask

   task automatic write_reg(input lfd_csr_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      if (idx == CSR_LENGTH_FIELD_OFFSET) cfg_offset = value[OFFSET_W-1:0];
      else cfg_field_bytes = value[FIELD_BYTES_W-1:0];
      framing_writes++;
   endtask

   // Idle the stream, then reprogram both framing registers
   task automatic set_framing(input int offset, input int field_bytes);
      logic [CSR_DATA_W-1:0] fb;
      drain_results();
      fb = CSR_DATA_W'(field_bytes);
      // the spare top data bit must be ignored by the byte-count register
      fb[CSR_DATA_W-1] = 1'($urandom_range(0, 1));
      write_reg(CSR_LENGTH_FIELD_OFFSET, CSR_DATA_W'(offset));
      write_reg(CSR_LENGTH_FIELD_BYTES, fb);
   endtask

   // Send the first 'limit' bytes of a packet with payload length plen
   task automatic send_packet(input int unsigned plen, input int limit);
      int hdr_len;
      int shift;
      logic [7:0] b;
      hdr_len = int'(cfg_offset) + active_field_bytes();
      for (int i = 0; i < hdr_len + int'(plen) && i < limit; i++) begin
         if (i < int'(cfg_offset) || i >= hdr_len) begin
            b = 8'($urandom_range(0, 255));
         end else begin
            shift = 8 * (hdr_len - 1 - i);
            b = 8'(plen >> shift);
         end
         push_stream_byte(b);
      end
   endtask

   function automatic int unsigned pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 0;
      if (r < 80) return $urandom_range(1, 16);
      if (r < 95) return $urandom_range(17, 64);
      return $urandom_range(65, active_field_bytes() == 1 ? 255 : 300);
   endfunction

   // Finish whatever packet is open; zeros in the length field keep it short
   task automatic resync_stream();
      while (in_payload || hdr_pos != '0) begin
         if (!in_payload && int'(hdr_pos) >= int'(cfg_offset)) push_stream_byte(8'h00);
         else push_stream_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic run_phase(input int offset, input int field_bytes, input int target);
      int start_count;
      int hdr_len;
      int plen;
      set_framing(offset, field_bytes);
      resync_stream();
      start_count = bytes_sent;
      while (bytes_sent - start_count < target) send_packet(pick_length(), 1 << 30);
      hdr_len = int'(cfg_offset) + active_field_bytes();
      // leave a packet open so the next setting lands mid-header or mid-payload
      case ($urandom_range(0, 2))
         1: begin
            if (hdr_len > 1) send_packet(0, $urandom_range(1, hdr_len - 1));
         end
         2: begin
            plen = $urandom_range(2, 20);
            send_packet(plen, hdr_len + $urandom_range(1, plen - 1));
         end
         default: ;
      endcase
   endtask

   task automatic test_directed();
      // reset framing: offset 3, two length bytes; zero length ends on the header
      push_stream_byte(8'hFF);
      push_stream_byte(8'h00);
      push_stream_byte(8'h80);
      push_stream_byte(8'h00);
      push_stream_byte(8'h00);
      send_packet(1, 1 << 30);
      // one-byte header carrying the length itself, then a header-only packet
      set_framing(0, 1);
      push_stream_byte(8'h02);
      push_stream_byte(8'hFF);
      push_stream_byte(8'h00);
      push_stream_byte(8'h00);
      // shrink the header after its end has already gone by
      set_framing(6, 1);
      push_stream_byte(8'hA5);
      push_stream_byte(8'h5A);
      push_stream_byte(8'hFF);
      push_stream_byte(8'h00);
      set_framing(0, 1);
      push_stream_byte(8'h3C);
   endtask

   task automatic test_framing_sweep();
      int offs[8] = '{0, 15, 0, 15, 7, 2, 1, 3};
      int nbs[8]  = '{1, 4, 0, 7, 3, 5, 2, 2};
      foreach (offs[i]) run_phase(offs[i], nbs[i], 150);
      while (bytes_sent < 1300) run_phase($urandom_range(0, 15), $urandom_range(0, 7), 120);
   endtask

   task automatic test_backpressure();
      run_phase(4, 2, 0);
      resync_stream();
      sender_steady = 1'b1;
      long_hold_req = 1'b1;
      repeat (3) send_packet(20, 1 << 30);
      sender_steady = 1'b0;
   endtask

   task automatic test_sender_pause();
      send_packet(pick_length(), 1 << 30);
      drain_results();
      send_packet(pick_length(), 1 << 30);
   endtask

   task automatic test_steady_stream();
      int start_count;
      run_phase(2, 3, 0);
      sender_steady = 1'b1;
      sink_steady   = 1'b1;
      start_count = bytes_sent;
      while (bytes_sent - start_count < 150) send_packet(pick_length(), 1 << 30);
      sender_steady = 1'b0;
      sink_steady   = 1'b0;
   endtask

   // Receiver: random stalls, plus one long hold counted here
   always @(negedge clock) begin
      if (long_hold_req) begin
         hold_left = LONG_HOLD;
         long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= sink_steady || ($urandom_range(0, 99) >= 10);
      end
   end

   always @(posedge clock) begin
      deframed_word_type got;
      deframed_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.data             = rsp_tdata;
         got.tag.packet_start = rsp_tuser[0];
         got.tag.in_header    = rsp_tuser[1];
         got.tag.packet_end   = rsp_tlast;
         if (pending_words.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected word data=%h start=%b end=%b hdr=%b", $time,
                     got.data, got.tag.packet_start, got.tag.packet_end, got.tag.in_header);
         end else begin
            want = pending_words.pop_front();
            words_checked++;
            if (got.tag.packet_end) packets_closed++;
            if (got !== want) begin
               mismatch_count++;
               $display({"%0t: expected data=%h start=%b end=%b hdr=%b,",
                         " got data=%h start=%b end=%b hdr=%b"},
                        $time, want.data, want.tag.packet_start, want.tag.packet_end,
                        want.tag.in_header, got.data, got.tag.packet_start,
                        got.tag.packet_end, got.tag.in_header);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  pending_words.size());
         $display("tb_length_field_deframer_core: done, errors");
         $finish;
      end
   end

   initial begin
      cfg_offset      = OFFSET_RESET;
      cfg_field_bytes = FIELD_BYTES_RESET;
      hdr_pos         = '0;
      length_accum    = '0;
      payload_left    = '0;
      in_payload      = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed();
      test_framing_sweep();
      test_backpressure();
      test_sender_pause();
      test_steady_stream();
      drain_results();

      $display("checked %0d words in %0d packets across %0d register writes,", words_checked,
               packets_closed, framing_writes);
      $display("covering header lengths 1 to 19, clamped field widths, %s",
               "mid-packet reframing and stalls");
      if (mismatch_count == 0) begin
         $display("tb_length_field_deframer_core: done, clean");
      end else begin
         $display("tb_length_field_deframer_core: done, errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/lfd_pkg.sv
hdl/lfd_tracker.sv
hdl/length_field_deframer_core.sv
hdl/lfd_checker.sv
verif/tb_length_field_deframer_core.sv
